// ----- hdl/prts_pkg.sv -----
// Package for the periodic report table scheduler: widths, codes, state
// encoding and the controller/datapath command and status structs.
// No dependencies.
package prts_pkg;

  localparam int TableSlots = 16;
  localparam int SlotW      = $clog2(TableSlots);
  localparam int CountW     = $clog2(TableSlots + 1);
  localparam int ParamLimit = 32;

  typedef enum logic [2:0] {
    FN_CREATE = 3'd0,
    FN_DELETE = 3'd1,
    FN_SETEN  = 3'd2,
    FN_FIND   = 3'd3,
    FN_DUE    = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_BAD  = 3'd1,
    ST_MANY = 3'd2,
    ST_DUP  = 3'd3,
    ST_FULL = 3'd4,
    ST_NONE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_APPLY,
    S_OUT
  } state_t;

  typedef struct packed {
    logic         [2:0] func;
    logic        [15:0] entry_id;
    logic         [7:0] param_total;
    logic        [31:0] period_seconds;
    logic               enable_flag;
    logic        [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic         [2:0] status;
    logic               found;
    logic         [3:0] slot_index;
    logic        [15:0] hit_id;
    logic        [31:0] hit_period;
    logic               hit_enabled;
    logic        [31:0] hit_last_emit;
    logic         [7:0] hit_param_total;
    logic         [4:0] entry_count;
    logic        [31:0] change_generation;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, clear scan state
    logic scan;      // address slot idx_r, examine slot idx_d_r
    logic read_hit;  // start read of the chosen slot
    logic apply;     // write table, form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// ----- hdl/prts_if.sv -----
// Valid/ready channel interface carrying one payload type.
// Depends on prts_pkg for the payload types.
interface prts_req_if;
  logic             valid;
  logic             ready;
  prts_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prts_rsp_if;
  logic             valid;
  logic             ready;
  prts_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prts_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/prts_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module prts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/prts_ctrl.sv -----
// Controller state machine for the scheduler: sequences load, slot scan,
// hit read, table update and result transfer. Depends on prts_pkg.
module prts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  prts_pkg::sts_t  sts,
  output prts_pkg::cmd_t  cmd
);
  prts_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      prts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = prts_pkg::S_SCAN;
        end
      end
      prts_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = prts_pkg::S_READ;
        end
      end
      prts_pkg::S_READ: begin
        cmd.read_hit = 1'b1;
        state_nxt    = prts_pkg::S_APPLY;
      end
      prts_pkg::S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = prts_pkg::S_OUT;
      end
      prts_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = prts_pkg::S_IDLE;
        end
      end
      default: state_nxt = prts_pkg::S_IDLE;
    endcase
  end
endmodule

// ----- hdl/prts_dp.sv -----
// Datapath for the scheduler: table flags in flip-flops, entry fields in
// RAMs, one-slot-a-cycle scan, update and result register.
// Depends on prts_pkg and prts_ram.
module prts_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  prts_pkg::cmd_t  cmd,
  output prts_pkg::sts_t  sts,
  input  prts_pkg::req_t  req,
  input  logic [15:0]     min_id,
  output prts_pkg::rsp_t  rsp
);
  localparam int SW = prts_pkg::SlotW;
  localparam int CW = prts_pkg::CountW;

  prts_pkg::req_t        req_r;
  logic [prts_pkg::TableSlots-1:0] used_r, en_r;
  logic [CW-1:0]         count_r;
  logic [31:0]           gen_r;
  logic [SW-1:0]         idx_r;
  logic [SW-1:0]         idx_d_r;   // slot whose RAM data is now valid
  logic                  scan_v_r;
  logic                  match_v_r, free_v_r, due_v_r;
  logic [SW-1:0]         match_r, free_r, due_r;
  logic [31:0]           due_le_r;
  logic [SW-1:0]         sel;
  logic [SW-1:0]         raddr;
  logic                  we;
  logic [SW-1:0]         waddr;
  logic [15:0]           id_wd, id_rd;
  logic [31:0]           per_wd, per_rd;
  logic [31:0]           le_wd, le_rd;
  logic [7:0]            pt_wd, pt_rd;
  prts_pkg::rsp_t        rsp_r;
  prts_pkg::rsp_t        rsp_nxt;
  logic [CW-1:0]         count_nxt;
  logic [31:0]           gen_nxt;
  prts_pkg::func_t       fn;
  logic                  create_ok, delete_ok, seten_chg;
  logic                  hit, mine, lastc;
  logic [31:0]           age;

  prts_ram #(.Width(16), .Depth(prts_pkg::TableSlots)) u_id (
    .clk, .we, .waddr, .wdata(id_wd), .raddr, .rdata(id_rd));
  prts_ram #(.Width(32), .Depth(prts_pkg::TableSlots)) u_per (
    .clk, .we, .waddr, .wdata(per_wd), .raddr, .rdata(per_rd));
  prts_ram #(.Width(32), .Depth(prts_pkg::TableSlots)) u_le (
    .clk, .we, .waddr, .wdata(le_wd), .raddr, .rdata(le_rd));
  prts_ram #(.Width(8), .Depth(prts_pkg::TableSlots)) u_pt (
    .clk, .we, .waddr, .wdata(pt_wd), .raddr, .rdata(pt_rd));

  assign fn = prts_pkg::func_t'(req_r.func);

  // slot picked for the hit read
  always_comb begin
    case (fn)
      prts_pkg::FN_DUE: sel = due_r;
      default:          sel = match_r;
    endcase
  end

  assign raddr = cmd.read_hit ? sel : idx_r;
  assign lastc = (idx_r == SW'(prts_pkg::TableSlots - 1));
  assign sts.scan_last = scan_v_r && (idx_d_r == SW'(prts_pkg::TableSlots - 1));
  assign mine  = used_r[idx_d_r];
  assign age   = req_r.now_time - le_rd;
  assign hit   = (fn == prts_pkg::FN_DUE) ? due_v_r : match_v_r;

  // operations that change the table
  assign create_ok = (fn == prts_pkg::FN_CREATE)
                     && (req_r.param_total != '0) && (req_r.entry_id >= min_id)
                     && (req_r.param_total <= 8'(prts_pkg::ParamLimit))
                     && !match_v_r && free_v_r;
  assign delete_ok = (fn == prts_pkg::FN_DELETE) && match_v_r;
  assign seten_chg = (fn == prts_pkg::FN_SETEN) && match_v_r
                     && (en_r[match_r] != req_r.enable_flag);

  // table write on create success or due stamp
  always_comb begin
    we     = 1'b0;
    waddr  = free_r;
    id_wd  = req_r.entry_id;
    per_wd = req_r.period_seconds;
    le_wd  = '0;
    pt_wd  = req_r.param_total;
    if (cmd.apply) begin
      case (fn)
        prts_pkg::FN_CREATE: begin
          we = create_ok;
        end
        prts_pkg::FN_DUE: begin
          we     = due_v_r;
          waddr  = due_r;
          id_wd  = id_rd;
          per_wd = per_rd;
          le_wd  = req_r.now_time;
          pt_wd  = pt_rd;
        end
        default: we = 1'b0;
      endcase
    end
  end

  // form the result and the next counts
  always_comb begin
    rsp_nxt        = '0;
    rsp_nxt.status = prts_pkg::ST_OK;
    case (fn)
      prts_pkg::FN_CREATE: begin
        if (req_r.param_total == '0 || req_r.entry_id < min_id) begin
          rsp_nxt.status = prts_pkg::ST_BAD;
        end else if (req_r.param_total > 8'(prts_pkg::ParamLimit)) begin
          rsp_nxt.status = prts_pkg::ST_MANY;
        end else if (match_v_r) begin
          rsp_nxt.status = prts_pkg::ST_DUP;
        end else if (!free_v_r) begin
          rsp_nxt.status = prts_pkg::ST_FULL;
        end
      end
      prts_pkg::FN_DELETE, prts_pkg::FN_SETEN, prts_pkg::FN_FIND: begin
        if (!match_v_r) begin
          rsp_nxt.status = prts_pkg::ST_NONE;
        end
      end
      prts_pkg::FN_DUE: rsp_nxt.status = prts_pkg::ST_OK;
      default: rsp_nxt.status = prts_pkg::ST_BAD;
    endcase
    count_nxt = count_r;
    if (create_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (delete_ok) begin
      count_nxt = count_r - 1'b1;
    end
    gen_nxt = gen_r;
    if (create_ok || delete_ok || seten_chg) begin
      gen_nxt = gen_r + 1'b1;
    end
    rsp_nxt.entry_count       = 5'(count_nxt);
    rsp_nxt.change_generation = gen_nxt;
    // hit fields for find and due
    if (hit && (fn == prts_pkg::FN_FIND || fn == prts_pkg::FN_DUE)) begin
      rsp_nxt.found           = 1'b1;
      rsp_nxt.slot_index      = 4'(sel);
      rsp_nxt.hit_id          = id_rd;
      rsp_nxt.hit_period      = per_rd;
      rsp_nxt.hit_enabled     = en_r[sel];
      rsp_nxt.hit_param_total = pt_rd;
      rsp_nxt.hit_last_emit   = (fn == prts_pkg::FN_DUE) ? req_r.now_time : le_rd;
    end
  end

  // scan, flags, counters and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
      gen_r   <= '0;
      scan_v_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        req_r     <= req;
        idx_r     <= '0;
        scan_v_r  <= 1'b0;
        match_v_r <= 1'b0;
        free_v_r  <= 1'b0;
        due_v_r   <= 1'b0;
      end
      if (cmd.scan) begin
        // advance address; RAM data for idx_d_r arrives in the next cycle
        idx_d_r  <= idx_r;
        scan_v_r <= 1'b1;
        if (!lastc) begin
          idx_r <= idx_r + 1'b1;
        end
        if (scan_v_r) begin
          if (mine && id_rd == req_r.entry_id && !match_v_r) begin
            match_v_r <= 1'b1;
            match_r   <= idx_d_r;
          end
          if (!mine && !free_v_r) begin
            free_v_r <= 1'b1;
            free_r   <= idx_d_r;
          end
          if (mine && en_r[idx_d_r] && per_rd != '0 && age >= per_rd
              && (!due_v_r || le_rd < due_le_r)) begin
            due_v_r  <= 1'b1;
            due_r    <= idx_d_r;
            due_le_r <= le_rd;
          end
        end
      end
      if (cmd.apply) begin
        rsp_r   <= rsp_nxt;
        count_r <= count_nxt;
        gen_r   <= gen_nxt;
        if (create_ok) begin
          used_r[free_r] <= 1'b1;
          en_r[free_r]   <= 1'b0;
        end
        if (delete_ok) begin
          used_r[match_r] <= 1'b0;
        end
        if (seten_chg) begin
          en_r[match_r] <= req_r.enable_flag;
        end
      end
    end
  end

  assign rsp = rsp_r;
endmodule

// ----- hdl/periodic_report_table_scheduler.sv -----
// Top level of the periodic report table scheduler.
//   channel | dir | payload
//   in_     | in  | func, entry_id, param_total, period_seconds, enable_flag, now_time
//   out_    | out | status, found, slot_index, hit_*, entry_count, change_generation
//   cfg_    | in  | min_identifier (16 bit)
// Each item is loaded, scanned one slot a cycle over the entry RAMs, read,
// applied and then held until the output takes it.
// rst_n (synchronous) empties the table, zeroes the counts and sets
// min_identifier to 1. A stalled result holds until transferred; no new
// item is taken meanwhile. Depends on prts_pkg, prts_if, prts_ctrl, prts_dp.
module periodic_report_table_scheduler (
  input  logic clk,
  input  logic rst_n,
  prts_req_if.sink   in_ch,
  prts_rsp_if.source out_ch,
  prts_cfg_if.sink   cfg_ch
);
  prts_pkg::cmd_t cmd;
  prts_pkg::sts_t sts;
  logic [15:0]    min_id_r;

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_id_r <= 16'd1;
    end else if (cfg_ch.valid) begin
      min_id_r <= cfg_ch.data;
    end
  end

  prts_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd);

  prts_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .req(in_ch.data), .min_id(min_id_r), .rsp(out_ch.data));
endmodule

// ----- dv/tb_periodic_report_table_scheduler.sv -----
// Self-checking testbench for the periodic report table scheduler: directed and
// random create/delete/enable/find/due traffic checked against a behavioural table.
// Depends on prts_pkg, prts_if and the periodic_report_table_scheduler RTL.
module tb_periodic_report_table_scheduler;

  localparam int IdleWait = 60;
  localparam int HoldCycles = 400;

  logic clk;
  logic rst_n;

  prts_req_if in_ch ();
  prts_rsp_if out_ch ();
  prts_cfg_if cfg_ch ();

  periodic_report_table_scheduler u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // behavioural copy of the table
  logic        tbl_used    [prts_pkg::TableSlots];
  logic [15:0] tbl_id      [prts_pkg::TableSlots];
  logic [31:0] tbl_period  [prts_pkg::TableSlots];
  logic [31:0] tbl_last    [prts_pkg::TableSlots];
  logic        tbl_en      [prts_pkg::TableSlots];
  logic [7:0]  tbl_params  [prts_pkg::TableSlots];
  logic [4:0]  tbl_count;
  logic [31:0] tbl_gen;
  logic [15:0] min_id;

  prts_pkg::req_t pending_reqs[$];
  prts_pkg::rsp_t expected_rsps[$];
  int   fail_count;
  logic hold_off;
  logic hold_go;
  logic [15:0] pool[8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // long receiver hold-off, counted in cycles here
  initial begin
    hold_off = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic int find_slot(logic [15:0] id);
    for (int i = 0; i < prts_pkg::TableSlots; i++) begin
      if (tbl_used[i] && tbl_id[i] == id) return i;
    end
    return prts_pkg::TableSlots;
  endfunction

  // compute the result of one request and update the table copy
  function automatic prts_pkg::rsp_t schedule_step(prts_pkg::req_t r);
    prts_pkg::rsp_t o;
    int   s;
    o = '0;
    o.status = prts_pkg::ST_OK;
    case (r.func)
      prts_pkg::FN_CREATE: begin
        if (r.param_total == 0 || r.entry_id < min_id) begin
          o.status = prts_pkg::ST_BAD;
        end else if (r.param_total > prts_pkg::ParamLimit) begin
          o.status = prts_pkg::ST_MANY;
        end else if (find_slot(r.entry_id) < prts_pkg::TableSlots) begin
          o.status = prts_pkg::ST_DUP;
        end else begin
          s = prts_pkg::TableSlots;
          for (int i = prts_pkg::TableSlots - 1; i >= 0; i--) begin
            if (!tbl_used[i]) s = i;
          end
          if (s == prts_pkg::TableSlots) begin
            o.status = prts_pkg::ST_FULL;
          end else begin
            tbl_used[s] = 1'b1;
            tbl_id[s] = r.entry_id;
            tbl_period[s] = r.period_seconds;
            tbl_last[s] = '0;
            tbl_en[s] = 1'b0;
            tbl_params[s] = r.param_total;
            tbl_count++;
            tbl_gen++;
          end
        end
      end
      prts_pkg::FN_DELETE: begin
        s = find_slot(r.entry_id);
        if (s == prts_pkg::TableSlots) begin
          o.status = prts_pkg::ST_NONE;
        end else begin
          tbl_used[s] = 1'b0;
          tbl_count--;
          tbl_gen++;
        end
      end
      prts_pkg::FN_SETEN: begin
        s = find_slot(r.entry_id);
        if (s == prts_pkg::TableSlots) begin
          o.status = prts_pkg::ST_NONE;
        end else if (tbl_en[s] != r.enable_flag) begin
          tbl_en[s] = r.enable_flag;
          tbl_gen++;
        end
      end
      prts_pkg::FN_FIND, prts_pkg::FN_DUE: begin
        if (r.func == prts_pkg::FN_FIND) begin
          s = find_slot(r.entry_id);
          if (s == prts_pkg::TableSlots) o.status = prts_pkg::ST_NONE;
        end else begin
          s = prts_pkg::TableSlots;
          for (int i = 0; i < prts_pkg::TableSlots; i++) begin
            if (tbl_used[i] && tbl_en[i] && tbl_period[i] != 0 &&
                32'(r.now_time - tbl_last[i]) >= tbl_period[i] &&
                (s == prts_pkg::TableSlots || tbl_last[i] < tbl_last[s])) s = i;
          end
          if (s < prts_pkg::TableSlots) tbl_last[s] = r.now_time;
        end
        if (s < prts_pkg::TableSlots) begin
          o.found = 1'b1;
          o.slot_index = 4'(s);
          o.hit_id = tbl_id[s];
          o.hit_period = tbl_period[s];
          o.hit_enabled = tbl_en[s];
          o.hit_last_emit = tbl_last[s];
          o.hit_param_total = tbl_params[s];
        end
      end
      default: o.status = prts_pkg::ST_BAD;
    endcase
    o.entry_count = tbl_count;
    o.change_generation = tbl_gen;
    return o;
  endfunction

  // driver: bursts with random gaps
  int gap_left;
  int burst_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_reqs.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predict at the accepting edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) expected_rsps.push_back(schedule_step(in_ch.data));
  end

  // receiver stall pattern, with an optional long hold-off
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_off) out_ch.ready <= 1'b0;
      else if (stall_phase[9]) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    prts_pkg::rsp_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, out_ch.data);
        fail_count++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (exp_r != out_ch.data) begin
          $display("%0t result mismatch: expected %p actual %p", $time, exp_r, out_ch.data);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_req(logic [2:0] f, logic [15:0] id, logic [7:0] p,
                           logic [31:0] per, logic en, logic [31:0] now);
    prts_pkg::req_t r;
    r.func = f;
    r.entry_id = id;
    r.param_total = p;
    r.period_seconds = per;
    r.enable_flag = en;
    r.now_time = now;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic write_min_id(logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    min_id = v;
  endtask

  // mostly well-formed traffic on a small identifier pool
  task automatic random_phase(int n, logic [31:0] base_now);
    logic [31:0] now;
    int          pick;
    logic [15:0] id;
    now = base_now;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      id = pool[$urandom_range(0, 7)];
      if (pick < 3) id = 16'($urandom);
      if (pick < 22) begin
        queue_req(prts_pkg::FN_CREATE, id,
                  $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(1, 32)),
                  $urandom_range(0, 7) == 0 ? 32'($urandom) : 32'($urandom_range(0, 20)),
                  1'($urandom), 32'($urandom));
      end else if (pick < 32) begin
        queue_req(prts_pkg::FN_DELETE, id, 8'($urandom), 32'($urandom), 1'($urandom),
                  32'($urandom));
      end else if (pick < 50) begin
        queue_req(prts_pkg::FN_SETEN, id, 8'($urandom), 32'($urandom),
                  $urandom_range(0, 3) != 0, 32'($urandom));
      end else if (pick < 62) begin
        queue_req(prts_pkg::FN_FIND, id, 8'($urandom), 32'($urandom), 1'($urandom),
                  32'($urandom));
      end else if (pick < 97) begin
        now = now + $urandom_range(0, 6);
        if ($urandom_range(0, 19) == 0) now = 32'($urandom);
        queue_req(prts_pkg::FN_DUE, id, 8'($urandom), 32'($urandom), 1'($urandom), now);
      end else begin
        queue_req(3'($urandom_range(5, 7)), id, 8'($urandom), 32'($urandom), 1'($urandom),
                  32'($urandom));
      end
    end
  endtask

  initial begin
    int n;
    fail_count = 0;
    hold_go = 1'b0;
    min_id = 16'd1;
    tbl_count = '0;
    tbl_gen = '0;
    for (int i = 0; i < prts_pkg::TableSlots; i++) begin
      tbl_used[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_period[i] = '0;
      tbl_last[i] = '0;
      tbl_en[i] = 1'b0;
      tbl_params[i] = '0;
    end
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: argument checks, duplicate, full table, wrap of elapsed time
    queue_req(prts_pkg::FN_CREATE, 16'd0, 8'd5, 32'd3, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_CREATE, 16'd5, 8'd0, 32'd3, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_CREATE, 16'd5, 8'd33, 32'd3, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_CREATE, 16'd5, 8'd255, 32'd3, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_CREATE, 16'hFFFF, 8'd32, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    queue_req(prts_pkg::FN_CREATE, 16'hFFFF, 8'd1, 32'd1, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_SETEN, 16'hFFFF, 8'd0, 32'd0, 1'b1, 32'd0);
    queue_req(prts_pkg::FN_SETEN, 16'hFFFF, 8'd0, 32'd0, 1'b1, 32'd0);
    queue_req(prts_pkg::FN_DUE, 16'd0, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFE);
    queue_req(prts_pkg::FN_DUE, 16'd0, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    queue_req(prts_pkg::FN_FIND, 16'hFFFF, 8'd0, 32'd0, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_FIND, 16'd7, 8'd0, 32'd0, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_DELETE, 16'd7, 8'd0, 32'd0, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_SETEN, 16'd7, 8'd0, 32'd0, 1'b1, 32'd0);
    for (int i = 0; i < 16; i++) begin
      queue_req(prts_pkg::FN_CREATE, 16'(100 + i), 8'd1, 32'd0, 1'b0, 32'd0);
    end
    queue_req(prts_pkg::FN_DELETE, 16'hFFFF, 8'd0, 32'd0, 1'b0, 32'd0);
    queue_req(prts_pkg::FN_CREATE, 16'd200, 8'd2, 32'd5, 1'b0, 32'd0);
    queue_req(3'd7, 16'd0, 8'd0, 32'd0, 1'b0, 32'd0);
    drain();

    // back-pressure: long receiver hold-off while the sender keeps offering
    for (int i = 0; i < prts_pkg::TableSlots; i++) begin
      queue_req(prts_pkg::FN_DELETE, 16'(100 + i), 8'd0, 32'd0, 1'b0, 32'd0);
    end
    hold_go = 1'b1;
    drain();

    // random phases over several minimum identifier settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_min_id(16'd0);
        1: write_min_id(16'hFFFF);
        2: write_min_id(16'd1);
        default: write_min_id(16'($urandom_range(0, 40000)));
      endcase
      for (int i = 0; i < 8; i++) begin
        pool[i] = (i == 0) ? 16'hFFFF : (i == 1) ? 16'd0 : 16'($urandom);
      end
      if (ph == 1) n = 60;
      else n = 400;
      random_phase(n, ph == 4 ? 32'hFFFF_FF00 : 32'($urandom));
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
